/* rtl/core/lpvc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpvc_pkg: shared types and constants of the LIFO victim and clean scan block
// Transaction payloads, action codes, sequencer states and flag encodings.
// ----------------------------------------------------------------------------
package lpvc_pkg;

    // Default geometry of the cache.
    localparam int DEF_WAYS = 16;
    localparam int DEF_SETS = 64;

    // Number of codes of the set_number field; each maps onto a set.
    localparam int SET_CODES = 64;

    // Block flag encodings: bit0 valid, bit1 dirty, bit2 other io, bit3 disk write.
    localparam logic [3:0] FLAG_VALID      = 4'b0001;
    localparam logic [3:0] FLAG_DISK_WRITE = 4'b1000;
    // Flag bits 3..1 of a block that the clean scan may mark.
    localparam logic [2:0] CLEAN_ELIGIBLE  = 3'b001;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_FIND  = 2'd1,
        ACT_CLEAN = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PTR,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [5:0]  set_number;
        logic [3:0]  way;
        logic [3:0]  new_state;
        logic [4:0]  clean_limit;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [3:0]  victim_way;
        logic [4:0]  writes_started;
    } t_out_item;

    // Status of one scan step.
    typedef struct packed {
        logic hit;
        logic mark;
        logic stop;
    } t_scan_sts;

endpackage
`default_nettype wire

/* rtl/core/lpvc_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpvc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpvc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/lpvc_scan_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpvc_scan_unit: shared step unit of the set scan
// Compares one block's flags, steps the way index downward with wraparound
// and advances the scan and write counts.
// ----------------------------------------------------------------------------
module lpvc_scan_unit #(
    parameter int WAYS = lpvc_pkg::DEF_WAYS,
    localparam int WW = $clog2(WAYS)
) (
    input  wire lpvc_pkg::t_action   i_action,
    input  wire logic [3:0]          i_flags,
    input  wire logic [WW-1:0]       i_idx,
    input  wire logic [WW-1:0]       i_scanned,
    input  wire logic [4:0]          i_writes,
    input  wire logic [4:0]          i_limit,
    output logic      [WW-1:0]       o_idx_below,
    output logic      [WW-1:0]       o_scanned_nx,
    output logic      [4:0]          o_writes_nx,
    output logic      [3:0]          o_flags_mark,
    output lpvc_pkg::t_scan_sts      o_sts
);

    logic is_find;
    logic is_clean;
    logic last;

    assign is_find  = (i_action == lpvc_pkg::ACT_FIND);
    assign is_clean = (i_action == lpvc_pkg::ACT_CLEAN);

    // Next way below the current one, wrapping to the top way.
    assign o_idx_below = (i_idx == '0) ? WW'(WAYS - 1) : i_idx - 1'b1;

    // Flag compare for both scan kinds.
    assign o_sts.hit  = is_find && (i_flags == lpvc_pkg::FLAG_VALID);
    assign o_sts.mark = is_clean && (i_flags[3:1] == lpvc_pkg::CLEAN_ELIGIBLE);

    assign o_flags_mark = i_flags | lpvc_pkg::FLAG_DISK_WRITE;
    assign o_writes_nx  = i_writes + 5'(o_sts.mark);
    assign o_scanned_nx = i_scanned + 1'b1;

    // The step on the last way of the set always ends the scan.
    assign last = (32'(i_scanned) == WAYS - 1);

    // A find stops on a hit, a clean stops when the limit is reached; either stops on the last way.
    assign o_sts.stop = is_find ? (o_sts.hit || last)
                                : (last || (o_writes_nx == i_limit));

endmodule
`default_nettype wire

/* rtl/core/per_set_lifo_victim_and_clean_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// per_set_lifo_victim_and_clean_scan: set-associative replacement engine
// Sequence: a write or unused action goes from the idle state straight to the
// response state; find and clean pass through the pointer fetch and then scan
// k ways, k being the ways scanned (0..WAYS, one flag RAM read each; a clean
// with a zero limit scans none), before the response state registers the result.
// Throughput: one transaction at a time; the next is taken the cycle after
// the result is registered. After reset a clearing pass over SETS * 2**clog2(WAYS)
// flag entries (1024 by default) zeroes flags and pointers before the first accept.
// ----------------------------------------------------------------------------
module per_set_lifo_victim_and_clean_scan #(
    parameter int WAYS = lpvc_pkg::DEF_WAYS,
    parameter int SETS = lpvc_pkg::DEF_SETS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lpvc_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lpvc_pkg::t_out_item      o_out_data
);

    localparam int WW     = $clog2(WAYS);
    localparam int SW     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int FDEPTH = SETS * (2 ** WW);
    localparam int FAW    = $clog2(FDEPTH);

    // Sequencer and transaction registers.
    lpvc_pkg::t_state    r_state, n_state;
    logic [FAW-1:0]      r_clr_addr, n_clr_addr;
    lpvc_pkg::t_action   r_act, n_act;
    logic [SW-1:0]       r_set, n_set;
    logic [WW-1:0]       r_idx, n_idx;
    logic [WW-1:0]       r_scanned, n_scanned;
    logic [4:0]          r_writes, n_writes;
    logic [4:0]          r_limit, n_limit;
    logic                r_found, n_found;
    logic [WW-1:0]       r_vway, n_vway;
    logic [2*WW-1:0]     r_ptrs, n_ptrs;
    logic                r_out_vld, n_out_vld;
    lpvc_pkg::t_out_item r_out, n_out;

    // Memory ports.
    logic                f_we;
    logic [FAW-1:0]      f_waddr;
    logic [3:0]          f_wdata;
    logic [FAW-1:0]      f_raddr;
    logic [3:0]          f_rdata;
    logic                p_we;
    logic [SW-1:0]       p_waddr;
    logic [2*WW-1:0]     p_wdata;
    logic [SW-1:0]       p_raddr;
    logic [2*WW-1:0]     p_rdata;

    // Scan unit results.
    logic [WW-1:0]       su_below;
    logic [WW-1:0]       su_scanned_nx;
    logic [4:0]          su_writes_nx;
    logic [3:0]          su_flags_mark;
    lpvc_pkg::t_scan_sts su_sts;

    // Request decode.
    logic [SW-1:0]       set_map [lpvc_pkg::SET_CODES];
    logic [SW-1:0]       in_set;
    logic [WW-1:0]       ptr_start;
    logic [4:0]          in_limit;
    logic                in_way_ok;

    // Flag RAM address of a block.
    function automatic logic [FAW-1:0] faddr(input logic [SW-1:0] s, input logic [WW-1:0] w);
        logic [SW+WW-1:0] cat;
        cat = {s, w};
        return cat[FAW-1:0];
    endfunction

    // Set numbers wrap onto the configured number of sets.
    for (genvar g = 0; g < lpvc_pkg::SET_CODES; g++) begin : g_set_map
        assign set_map[g] = SW'(g % SETS);
    end

    assign in_set    = set_map[i_in_data.set_number];
    assign in_way_ok = (32'(i_in_data.way) < WAYS);
    assign in_limit  = (32'(i_in_data.clean_limit) > WAYS) ? 5'(WAYS)
                                                           : i_in_data.clean_limit;
    assign ptr_start = (r_act == lpvc_pkg::ACT_FIND) ? p_rdata[2*WW-1:WW] : p_rdata[WW-1:0];
    assign p_raddr   = in_set;

    // Block flags, one entry per way of every set.
    lpvc_ram #(
        .WIDTH (4),
        .DEPTH (FDEPTH)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    // Victim pointer (upper half) and clean pointer (lower half) of every set.
    lpvc_ram #(
        .WIDTH (2 * WW),
        .DEPTH (SETS)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    lpvc_scan_unit #(
        .WAYS (WAYS)
    ) u_scan (
        .i_action     (r_act),
        .i_flags      (f_rdata),
        .i_idx        (r_idx),
        .i_scanned    (r_scanned),
        .i_writes     (r_writes),
        .i_limit      (r_limit),
        .o_idx_below  (su_below),
        .o_scanned_nx (su_scanned_nx),
        .o_writes_nx  (su_writes_nx),
        .o_flags_mark (su_flags_mark),
        .o_sts        (su_sts)
    );

    // Sequencer: next state, memory controls and result.
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_act      = r_act;
        n_set      = r_set;
        n_idx      = r_idx;
        n_scanned  = r_scanned;
        n_writes   = r_writes;
        n_limit    = r_limit;
        n_found    = r_found;
        n_vway     = r_vway;
        n_ptrs     = r_ptrs;
        n_out      = r_out;
        n_out_vld  = r_out_vld && i_out_stall;
        f_we       = 1'b0;
        f_waddr    = faddr(r_set, r_idx);
        f_wdata    = '0;
        f_raddr    = faddr(r_set, r_idx);
        p_we       = 1'b0;
        p_waddr    = r_set;
        p_wdata    = r_ptrs;
        o_in_stall = 1'b1;

        unique case (r_state)
            lpvc_pkg::ST_CLEAR: begin
                f_we    = 1'b1;
                f_waddr = r_clr_addr;
                f_wdata = '0;
                p_we    = (32'(r_clr_addr) < SETS);
                p_waddr = r_clr_addr[SW-1:0];
                p_wdata = '0;
                if (32'(r_clr_addr) == FDEPTH - 1) begin
                    n_state = lpvc_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end

            lpvc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_act     = i_in_data.action;
                    n_set     = in_set;
                    n_limit   = in_limit;
                    n_found   = 1'b0;
                    n_vway    = '0;
                    n_writes  = '0;
                    n_scanned = '0;
                    // A write action to a way in range stores the flags right away.
                    if (i_in_data.action == lpvc_pkg::ACT_WRITE && in_way_ok) begin
                        f_we    = 1'b1;
                        f_waddr = faddr(in_set, WW'(i_in_data.way));
                        f_wdata = i_in_data.new_state;
                    end
                    if (i_in_data.action == lpvc_pkg::ACT_FIND ||
                        i_in_data.action == lpvc_pkg::ACT_CLEAN) begin
                        n_state = lpvc_pkg::ST_PTR;
                    end else begin
                        n_state = lpvc_pkg::ST_RESP;
                    end
                end
            end

            lpvc_pkg::ST_PTR: begin
                // Pointers of the set are in; fetch the first block.
                n_ptrs  = p_rdata;
                n_idx   = ptr_start;
                f_raddr = faddr(r_set, ptr_start);
                if (r_act == lpvc_pkg::ACT_CLEAN && r_limit == '0) begin
                    n_state = lpvc_pkg::ST_RESP;
                end else begin
                    n_state = lpvc_pkg::ST_SCAN;
                end
            end

            lpvc_pkg::ST_SCAN: begin
                // Check one block and fetch the one below it.
                f_raddr   = faddr(r_set, su_below);
                n_writes  = su_writes_nx;
                n_scanned = su_scanned_nx;
                if (su_sts.mark) begin
                    f_we    = 1'b1;
                    f_waddr = faddr(r_set, r_idx);
                    f_wdata = su_flags_mark;
                end
                if (su_sts.stop) begin
                    n_state = lpvc_pkg::ST_RESP;
                end
                if (su_sts.hit) begin
                    n_found = 1'b1;
                    n_vway  = r_idx;
                end else begin
                    n_idx = su_below;
                end
            end

            lpvc_pkg::ST_RESP: begin
                // Store the moved pointer; rewriting it while waiting is harmless.
                p_we = (r_act == lpvc_pkg::ACT_FIND) || (r_act == lpvc_pkg::ACT_CLEAN);
                if (r_act == lpvc_pkg::ACT_FIND) begin
                    p_wdata = {su_below, r_ptrs[WW-1:0]};
                end else begin
                    p_wdata = {r_ptrs[2*WW-1:WW], r_idx};
                end
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld            = 1'b1;
                    n_out.found          = r_found;
                    n_out.victim_way     = 4'(r_vway);
                    n_out.writes_started = r_writes;
                    n_state              = lpvc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = lpvc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lpvc_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_out_vld  <= n_out_vld;
        end
    end

    // Transaction payload registers.
    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_set     <= n_set;
        r_idx     <= n_idx;
        r_scanned <= n_scanned;
        r_writes  <= n_writes;
        r_limit   <= n_limit;
        r_found   <= n_found;
        r_vway    <= n_vway;
        r_ptrs    <= n_ptrs;
        r_out     <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A result appears only from the response state.
    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == lpvc_pkg::ST_RESP)
        else $error("result raised outside the response state");

    // A clean scan step never starts with the limit already reached.
    a_clean_below_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpvc_pkg::ST_SCAN && r_act == lpvc_pkg::ACT_CLEAN)
            |-> r_writes < r_limit)
        else $error("clean scan step past its limit");

    // Only a find action reports a victim.
    a_found_only_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpvc_pkg::ST_RESP && r_found) |-> r_act == lpvc_pkg::ACT_FIND)
        else $error("victim reported by a non-find action");

    // The pointer fetch is always followed by a scan or the response.
    a_ptr_then_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lpvc_pkg::ST_PTR
            |=> (r_state == lpvc_pkg::ST_SCAN || r_state == lpvc_pkg::ST_RESP))
        else $error("pointer fetch not followed by scan or response");
`endif

endmodule
`default_nettype wire
